>>> hdl/gtb_pkg.sv
// Shared constants for the grid tile bounds block: port widths, register
// indexes, default limits and the placement pipeline depth.
// No dependencies.
package gtb_pkg;

    // Port widths
    localparam int IDX_W      = 20;  // tile index, also the divider step count
    localparam int CFG_GRID_W = 11;  // grid_rows, grid_columns
    localparam int CFG_DIM_W  = 14;  // image size and signed origin
    localparam int CFG_DATA_W = 14;  // widest register
    localparam int CFG_IDX_W  = 3;
    localparam int TILE_DIM_W = 14;  // tile_w, tile_h
    localparam int CORNER_W   = 13;  // tile_left, tile_top

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLUMNS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y     = 3'd5;

    // Default limits
    localparam int DEF_MAX_IMAGE_DIM = 8192;
    localparam int DEF_MAX_GRID      = 1024;

    // Register stages in one axis placement unit
    localparam int PLACE_STAGES = 4;

endpackage

>>> hdl/gtb_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on gtb_pkg for default widths.
module gtb_div #(
    parameter int DVD_W = gtb_pkg::IDX_W,
    parameter int DVS_W = gtb_pkg::CFG_GRID_W
) (
    input  logic             clk,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic [DVD_W-1:0] quotient,
    output logic [DVS_W-1:0] remainder
);
    import gtb_pkg::*;

    // Dividend bits shift out at the top while quotient bits shift in below
    logic [DVD_W-1:0] qd_reg  [DVD_W];
    logic [DVS_W-1:0] rem_reg [DVD_W];
    logic [DVS_W-1:0] dvs_reg [DVD_W];

    for (genvar i = 0; i < DVD_W; i++)
    begin : g_step
        logic [DVD_W-1:0] qd_in;
        logic [DVS_W-1:0] rem_in;
        logic [DVS_W-1:0] dvs_in;
        logic [DVS_W:0]   trial;
        logic [DVS_W:0]   diff;

        if (i == 0)
        begin : g_first
            assign qd_in  = dividend;
            assign rem_in = '0;
            assign dvs_in = divisor;
        end
        else
        begin : g_next
            assign qd_in  = qd_reg[i-1];
            assign rem_in = rem_reg[i-1];
            assign dvs_in = dvs_reg[i-1];
        end

        // rem stays below the divisor, so the trial fits one extra bit
        assign trial = {rem_in, qd_in[DVD_W-1]};
        assign diff  = trial - {1'b0, dvs_in};

        always_ff @(posedge clk)
        begin
            if (!diff[DVS_W])
            begin
                rem_reg[i] <= diff[DVS_W-1:0];
                qd_reg[i]  <= {qd_in[DVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg[i] <= trial[DVS_W-1:0];
                qd_reg[i]  <= {qd_in[DVD_W-2:0], 1'b0};
            end
            dvs_reg[i] <= dvs_in;
        end
    end

    assign quotient  = qd_reg[DVD_W-1];
    assign remainder = rem_reg[DVD_W-1];

endmodule

>>> hdl/gtb_axis.sv
// Placement of one tile along one axis: extent and wrapped start offset.
// Four register stages; depends on gtb_pkg.
module gtb_axis #(
    parameter int MAX_IMAGE_DIM = gtb_pkg::DEF_MAX_IMAGE_DIM,
    parameter int MAX_GRID      = gtb_pkg::DEF_MAX_GRID
) (
    input  logic                                   clk,
    input  logic [$clog2(MAX_GRID+1)-1:0]          seg,
    input  logic [$clog2(MAX_IMAGE_DIM+1)-1:0]     base,
    input  logic [$clog2(MAX_GRID+1)-1:0]          residue,
    input  logic [$clog2(MAX_IMAGE_DIM+1)-1:0]     origin_mod,
    input  logic                                   origin_neg,
    input  logic [$clog2(MAX_IMAGE_DIM+1)-1:0]     total,
    output logic [$clog2(MAX_IMAGE_DIM+1)-1:0]     seg_len,
    output logic [$clog2(MAX_IMAGE_DIM+1)-1:0]     seg_start
);
    import gtb_pkg::*;

    localparam int GRID_W = $clog2(MAX_GRID + 1);
    localparam int DIM_W  = $clog2(MAX_IMAGE_DIM + 1);
    localparam int PROD_W = GRID_W + DIM_W;

    logic              below;
    logic [PROD_W-1:0] prod_reg;
    logic [GRID_W-1:0] extra_reg;
    logic [DIM_W-1:0]  len1_reg, len2_reg, len3_reg, len4_reg;
    logic [DIM_W-1:0]  orig1_reg, orig2_reg;
    logic [DIM_W-1:0]  off_reg;
    logic [DIM_W:0]    sum_reg;
    logic [DIM_W-1:0]  start_reg;

    assign below = (seg < residue);

    always_ff @(posedge clk)
    begin
        // Stage 1: sum of earlier extents, split into product and clamp
        prod_reg  <= PROD_W'(seg) * PROD_W'(base);
        extra_reg <= below ? seg : residue;
        len1_reg  <= base + DIM_W'(below);
        // negative origin: flip its magnitude remainder onto the image
        orig1_reg <= (origin_neg && (origin_mod != '0)) ? (total - origin_mod) : origin_mod;

        // Stage 2: offset never exceeds the image size for a valid index
        off_reg   <= DIM_W'(prod_reg + PROD_W'(extra_reg));
        orig2_reg <= orig1_reg;
        len2_reg  <= len1_reg;

        // Stage 3
        sum_reg   <= (DIM_W+1)'(orig2_reg) + (DIM_W+1)'(off_reg);
        len3_reg  <= len2_reg;

        // Stage 4: sum is below twice the image size, one subtract wraps it
        start_reg <= (sum_reg >= (DIM_W+1)'(total)) ? DIM_W'(sum_reg - (DIM_W+1)'(total))
                                                    : DIM_W'(sum_reg);
        len4_reg  <= len3_reg;
    end

    assign seg_len   = len4_reg;
    assign seg_start = start_reg;

endmodule

>>> hdl/grid_tile_bounds.sv
// Top level of the grid tile bounds block: configuration registers, the
// divider pipelines, two axis placement units and the result register.
// Depends on gtb_pkg, gtb_div and gtb_axis.
//
//   Channel   Handshake              Payload
//   --------  ---------------------  ------------------------------------------
//   command   start, busy            tile_index
//   result    done (one-cycle pulse) tile_w, tile_h, tile_left, tile_top,
//                                    index_invalid
//   config    cfg_wr                 cfg_index, cfg_data
//
// One command per clock; busy is never raised. Each result passes through 20
// restoring divide steps for the tile index (the image size and origin divides
// run alongside), 4 placement stages and the result register. Reset clears the
// configuration to a 1x1 grid on a 1x1 image and empties the pipeline. The
// receiver cannot stall; results stream out in order.
module grid_tile_bounds #(
    parameter int MAX_IMAGE_DIM = gtb_pkg::DEF_MAX_IMAGE_DIM,
    parameter int MAX_GRID      = gtb_pkg::DEF_MAX_GRID
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [gtb_pkg::IDX_W-1:0]       tile_index,
    output logic                            done,
    output logic [gtb_pkg::TILE_DIM_W-1:0]  tile_w,
    output logic [gtb_pkg::TILE_DIM_W-1:0]  tile_h,
    output logic [gtb_pkg::CORNER_W-1:0]    tile_left,
    output logic [gtb_pkg::CORNER_W-1:0]    tile_top,
    output logic                            index_invalid,
    input  logic                            cfg_wr,
    input  logic [gtb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gtb_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import gtb_pkg::*;

    localparam int GRID_W = $clog2(MAX_GRID + 1);
    localparam int DIM_W  = $clog2(MAX_IMAGE_DIM + 1);
    localparam int LAT    = IDX_W + PLACE_STAGES + 1;

    // Configuration, stored already clamped to its legal range
    logic [GRID_W-1:0]           rows_reg, cols_reg;
    logic [DIM_W-1:0]            width_reg, height_reg;
    logic signed [CFG_DIM_W-1:0] ox_reg, oy_reg;
    logic [GRID_W-1:0]           grid_next;
    logic [DIM_W-1:0]            dim_next;
    logic [CFG_GRID_W-1:0]       grid_raw;
    logic [CFG_DIM_W-1:0]        dim_raw;

    logic [2*GRID_W-1:0]         cells_reg;
    logic [IDX_W-1:0]            idx_reg;
    logic [LAT-2:0]              vld_reg;
    logic [IDX_W+2:0]            bad_reg;
    logic                        accept;

    logic [CFG_DIM_W-1:0]        ox_mag, oy_mag;
    logic [IDX_W-1:0]            row_q, wx_q, hy_q, ox_q, oy_q;
    logic [GRID_W-1:0]           col_r, wx_r, hy_r;
    logic [DIM_W-1:0]            ox_r, oy_r;
    logic [DIM_W-1:0]            len_x, len_y, start_x, start_y;

    logic                        done_reg;
    logic [TILE_DIM_W-1:0]       tile_w_reg, tile_h_reg;
    logic [CORNER_W-1:0]         tile_left_reg, tile_top_reg;
    logic                        bad_out_reg;

    // The pipeline never stalls
    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign grid_raw = cfg_data[CFG_GRID_W-1:0];
    assign dim_raw  = cfg_data[CFG_DIM_W-1:0];

    always_comb
    begin
        if (grid_raw == '0)
            grid_next = GRID_W'(1);
        else if (32'(grid_raw) > 32'(MAX_GRID))
            grid_next = GRID_W'(MAX_GRID);
        else
            grid_next = GRID_W'(grid_raw);

        if (dim_raw == '0)
            dim_next = DIM_W'(1);
        else if (32'(dim_raw) > 32'(MAX_IMAGE_DIM))
            dim_next = DIM_W'(MAX_IMAGE_DIM);
        else
            dim_next = DIM_W'(dim_raw);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg   <= GRID_W'(1);
            cols_reg   <= GRID_W'(1);
            width_reg  <= DIM_W'(1);
            height_reg <= DIM_W'(1);
            ox_reg     <= '0;
            oy_reg     <= '0;
        end
        else if (cfg_wr)
        begin
            case (cfg_index)
                REG_GRID_ROWS:    rows_reg   <= grid_next;
                REG_GRID_COLUMNS: cols_reg   <= grid_next;
                REG_IMAGE_WIDTH:  width_reg  <= dim_next;
                REG_IMAGE_HEIGHT: height_reg <= dim_next;
                REG_ORIGIN_X:     ox_reg     <= signed'(dim_raw);
                REG_ORIGIN_Y:     oy_reg     <= signed'(dim_raw);
                default:          ;
            endcase
        end
    end

    // Valid bits travel alongside the divider and placement stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[LAT-3:0], accept};
    end

    // Index range check runs one stage behind the capture of the index
    always_ff @(posedge clk)
    begin
        cells_reg <= (2*GRID_W)'(rows_reg) * (2*GRID_W)'(cols_reg);
        idx_reg   <= tile_index;
        bad_reg   <= {bad_reg[IDX_W+1:0], (32'(idx_reg) >= 32'(cells_reg))};
    end

    assign ox_mag = ox_reg[CFG_DIM_W-1] ? unsigned'(-ox_reg) : unsigned'(ox_reg);
    assign oy_mag = oy_reg[CFG_DIM_W-1] ? unsigned'(-oy_reg) : unsigned'(oy_reg);

    gtb_div #(.DVD_W(IDX_W), .DVS_W(GRID_W)) u_div_idx (
        .clk       (clk),
        .dividend  (tile_index),
        .divisor   (cols_reg),
        .quotient  (row_q),
        .remainder (col_r)
    );

    gtb_div #(.DVD_W(IDX_W), .DVS_W(GRID_W)) u_div_wx (
        .clk       (clk),
        .dividend  (IDX_W'(width_reg)),
        .divisor   (cols_reg),
        .quotient  (wx_q),
        .remainder (wx_r)
    );

    gtb_div #(.DVD_W(IDX_W), .DVS_W(GRID_W)) u_div_hy (
        .clk       (clk),
        .dividend  (IDX_W'(height_reg)),
        .divisor   (rows_reg),
        .quotient  (hy_q),
        .remainder (hy_r)
    );

    gtb_div #(.DVD_W(IDX_W), .DVS_W(DIM_W)) u_div_ox (
        .clk       (clk),
        .dividend  (IDX_W'(ox_mag)),
        .divisor   (width_reg),
        .quotient  (ox_q),
        .remainder (ox_r)
    );

    gtb_div #(.DVD_W(IDX_W), .DVS_W(DIM_W)) u_div_oy (
        .clk       (clk),
        .dividend  (IDX_W'(oy_mag)),
        .divisor   (height_reg),
        .quotient  (oy_q),
        .remainder (oy_r)
    );

    gtb_axis #(.MAX_IMAGE_DIM(MAX_IMAGE_DIM), .MAX_GRID(MAX_GRID)) u_axis_x (
        .clk        (clk),
        .seg        (col_r),
        .base       (DIM_W'(wx_q)),
        .residue    (wx_r),
        .origin_mod (ox_r),
        .origin_neg (ox_reg[CFG_DIM_W-1]),
        .total      (width_reg),
        .seg_len    (len_x),
        .seg_start  (start_x)
    );

    gtb_axis #(.MAX_IMAGE_DIM(MAX_IMAGE_DIM), .MAX_GRID(MAX_GRID)) u_axis_y (
        .clk        (clk),
        .seg        (GRID_W'(row_q)),
        .base       (DIM_W'(hy_q)),
        .residue    (hy_r),
        .origin_mod (oy_r),
        .origin_neg (oy_reg[CFG_DIM_W-1]),
        .total      (height_reg),
        .seg_len    (len_y),
        .seg_start  (start_y)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= vld_reg[LAT-2];
    end

    // Drop the geometry of an out-of-range index
    always_ff @(posedge clk)
    begin
        if (vld_reg[LAT-2])
        begin
            bad_out_reg   <= bad_reg[IDX_W+2];
            tile_w_reg    <= bad_reg[IDX_W+2] ? '0 : TILE_DIM_W'(len_x);
            tile_h_reg    <= bad_reg[IDX_W+2] ? '0 : TILE_DIM_W'(len_y);
            tile_left_reg <= bad_reg[IDX_W+2] ? '0 : CORNER_W'(start_x);
            tile_top_reg  <= bad_reg[IDX_W+2] ? '0 : CORNER_W'(start_y);
        end
    end

    assign done          = done_reg;
    assign tile_w        = tile_w_reg;
    assign tile_h        = tile_h_reg;
    assign tile_left     = tile_left_reg;
    assign tile_top      = tile_top_reg;
    assign index_invalid = bad_out_reg;

endmodule
